@@ hdl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lpftxq_pkg.sv @@
// shared types and constants of the length-prefixed frame transmit queue
package lpftxq_pkg;

  typedef logic [7:0] byte_t;

  // beat widths on both channels
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;
  localparam int ROOM_W     = 6;
  localparam int FREE_W     = 4;

  // opcodes carried in s_tuser
  localparam logic [1:0] OP_BEGIN   = 2'd0;
  localparam logic [1:0] OP_PAYLOAD = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;
  localparam logic [1:0] OP_PUMP    = 2'd3;

  // result kinds carried in m_tuser
  localparam logic KIND_BYTE   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // enqueue status codes
  localparam logic [1:0] STS_OK         = 2'd0;
  localparam logic [1:0] STS_TOO_LONG   = 2'd1;
  localparam logic [1:0] STS_QUEUE_FULL = 2'd2;

  // slot layout: big-endian length header, then type byte, then payload
  localparam int HDR_BYTES    = 4;
  localparam int PAYLOAD_BASE = 5;

endpackage

@@ hdl/lpftxq_ram.sv @@
// generic single-write, single-read ram with registered read data
module lpftxq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/length_prefixed_frame_tx_queue_top.sv @@
// top level of the length-prefixed frame transmit queue
//
// Commands arrive as beats on the s_ channel, the opcode in s_tuser. Begin
// latches the type byte, payload writes one byte into the tail slot, end
// commits or rejects the frame, pump sends up to sink_room bytes of the head
// frame. Results leave on the m_ channel: m_tuser tells a sent byte from an
// enqueue status, m_tlast marks the last byte of a pump's run.
// Begin and payload leave the input ready. An end beat that commits writes the
// four header bytes and the type byte through the single ram write port, one
// per cycle, then loads its status, holding the input until that is done; a
// rejected end goes straight to the status state, which loads its status into
// the output register once that register is free. A pump reads the frame
// store one byte per cycle while the receiver keeps up: each byte passes from
// the ram read register to the output register; the input waits for the run.
// The output register lets a new command be taken while the last result
// still waits. When m_tready is low the byte reader stops after one byte is
// parked in the ram read register, and the input stays blocked.
// Reset empties the queue and the build state; the frame store is not
// cleared, since every byte read has been written by a committed frame.
module length_prefixed_frame_tx_queue_top #(
  parameter int QUEUE_SLOTS = 8,
  parameter int FRAME_BYTES = 256,
  parameter int MAX_ROOM    = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // frame_type [7:0], payload_byte [15:8], sink_room [21:16], zero [23:22]
  input  logic [lpftxq_pkg::IN_DATA_W-1:0]     s_tdata,
  // opcode [1:0]
  input  logic [1:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // tx_byte [7:0], status_code [9:8], free_slots [13:10], zero [15:14]
  output logic [lpftxq_pkg::OUT_DATA_W-1:0]    m_tdata,
  // result_kind [0]
  output logic [0:0]                           m_tuser,
  output logic                                 m_tlast
);

  import lpftxq_pkg::*;

  localparam int SLOT_W    = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
  localparam int POS_W     = $clog2(FRAME_BYTES);
  localparam int LEN_W     = $clog2(FRAME_BYTES + 1);
  localparam int HELD_W    = $clog2(QUEUE_SLOTS + 1);
  localparam int RUN_W     = $clog2(MAX_ROOM + 1);
  localparam int CW0       = (LEN_W > RUN_W) ? LEN_W : RUN_W;
  localparam int CW        = (CW0 > ROOM_W) ? CW0 : ROOM_W;
  localparam int FW        = (HELD_W + 1 > FREE_W) ? HELD_W + 1 : FREE_W;
  localparam int MEM_DEPTH = QUEUE_SLOTS * (2 ** POS_W);
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_HDR  = 2'd1;
  localparam logic [1:0] S_STAT = 2'd2;
  localparam logic [1:0] S_PUMP = 2'd3;

  logic [1:0]        state;
  logic [LEN_W-1:0]  slot_len [QUEUE_SLOTS];
  logic [LEN_W-1:0]  slot_off [QUEUE_SLOTS];
  logic [SLOT_W-1:0] head;
  logic [SLOT_W-1:0] tail;
  logic [HELD_W-1:0] held;
  logic [LEN_W-1:0]  build_len;
  logic              build_ovf;
  logic              build_blk;
  byte_t             build_type;
  logic [2:0]        hdr_idx;
  logic [1:0]        stat_code;
  logic [FREE_W-1:0] stat_free;
  logic [SLOT_W-1:0] rd_slot;
  logic [POS_W-1:0]  rd_pos;
  logic [RUN_W-1:0]  rd_left;
  logic              pend;
  logic              pend_last;
  logic [FREE_W-1:0] run_free;
  logic              out_kind;
  byte_t             out_byte;
  logic              out_last;
  logic [1:0]        out_status;
  logic [FREE_W-1:0] out_free;

  logic [1:0]        opcode;
  byte_t             frame_type;
  byte_t             payload_byte;
  logic [ROOM_W-1:0] sink_room;
  logic              accept;
  logic              full;
  logic              too_long;
  logic [FW-1:0]     free_now;
  logic [FW-1:0]     free_commit;
  logic [FW-1:0]     free_retire;
  logic [LEN_W-1:0]  head_len;
  logic [LEN_W-1:0]  head_off;
  logic [CW-1:0]     rem_c;
  logic [CW-1:0]     room_c;
  logic [CW-1:0]     run_c;
  logic              retire;
  logic [SLOT_W-1:0] head_inc;
  logic [SLOT_W-1:0] tail_inc;
  logic [31:0]       flen;
  logic [LEN_W-1:0]  pay_pos;
  logic              out_open;
  logic              move;
  logic              issue;
  logic              wr_en;
  logic [MEM_AW-1:0] wr_addr;
  byte_t             wr_data;
  logic [MEM_AW-1:0] rd_addr;
  byte_t             rd_data;

  // input beat fields
  assign opcode       = s_tuser;
  assign frame_type   = s_tdata[7:0];
  assign payload_byte = s_tdata[15:8];
  assign sink_room    = s_tdata[16 +: ROOM_W];

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // queue occupancy and free count
  assign full        = (held >= HELD_W'(QUEUE_SLOTS));
  assign free_now    = FW'(QUEUE_SLOTS) - FW'(held);
  assign free_commit = free_now - FW'(1);
  assign free_retire = free_now + FW'(1);
  assign too_long    = (build_len >= LEN_W'(FRAME_BYTES - PAYLOAD_BASE));
  assign head_inc    = (head == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : head + SLOT_W'(1);
  assign tail_inc    = (tail == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : tail + SLOT_W'(1);

  // run length of a pump: the smaller of what is left and the offered room, capped at MAX_ROOM
  assign head_len = slot_len[head];
  assign head_off = slot_off[head];
  assign rem_c    = CW'(head_len - head_off);
  assign room_c   = (CW'(sink_room) > CW'(MAX_ROOM)) ? CW'(MAX_ROOM) : CW'(sink_room);
  assign run_c    = (rem_c > room_c) ? room_c : rem_c;
  assign retire   = (run_c == rem_c);

  // header byte source while the frame is committed
  assign flen    = 32'(build_len) + 32'd1;
  assign pay_pos = build_len + LEN_W'(PAYLOAD_BASE);

  always_comb begin
    if (state == S_HDR) begin
      wr_en   = 1'b1;
      wr_addr = MEM_AW'({tail, POS_W'(hdr_idx)});
      if (hdr_idx == 3'(HDR_BYTES)) begin
        wr_data = build_type;
      end else begin
        wr_data = 8'(flen >> {2'd3 - hdr_idx[1:0], 3'b000});
      end
    end else begin
      wr_en   = accept && (opcode == OP_PAYLOAD) && !too_long && !full;
      wr_addr = MEM_AW'({tail, pay_pos[POS_W-1:0]});
      wr_data = payload_byte;
    end
  end

  // byte reader: one read in flight, parked data waits for the output register
  assign out_open = !m_tvalid || m_tready;
  assign move     = pend && out_open;
  assign issue    = (state == S_PUMP) && (rd_left != '0) && (!pend || move);
  assign rd_addr  = MEM_AW'({rd_slot, rd_pos});

  lpftxq_ram #(
    .WIDTH (8),
    .DEPTH (MEM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // sequencer, slot bookkeeping and build state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      held       <= '0;
      build_len  <= '0;
      build_ovf  <= 1'b0;
      build_blk  <= 1'b0;
      build_type <= '0;
      pend       <= 1'b0;
      for (int i = 0; i < QUEUE_SLOTS; i++) begin
        slot_len[i] <= '0;
        slot_off[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (opcode)
              OP_BEGIN: begin
                build_type <= frame_type;
                build_len  <= '0;
                build_ovf  <= 1'b0;
                build_blk  <= 1'b0;
              end
              OP_PAYLOAD: begin
                if (too_long) begin
                  build_ovf <= 1'b1;
                end else if (full) begin
                  build_blk <= 1'b1;
                end else begin
                  build_len <= build_len + LEN_W'(1);
                end
              end
              OP_END: begin
                if (build_ovf || build_blk || full) begin
                  stat_code <= build_ovf ? STS_TOO_LONG : STS_QUEUE_FULL;
                  stat_free <= free_now[FREE_W-1:0];
                  build_len <= '0;
                  build_ovf <= 1'b0;
                  build_blk <= 1'b0;
                  state     <= S_STAT;
                end else begin
                  hdr_idx <= '0;
                  state   <= S_HDR;
                end
              end
              default: begin
                if ((held != '0) && (sink_room != '0)) begin
                  rd_slot <= head;
                  rd_pos  <= head_off[POS_W-1:0];
                  rd_left <= run_c[RUN_W-1:0];
                  if (retire) begin
                    slot_len[head] <= '0;
                    slot_off[head] <= '0;
                    head           <= head_inc;
                    held           <= held - HELD_W'(1);
                    run_free       <= free_retire[FREE_W-1:0];
                  end else begin
                    slot_off[head] <= head_off + LEN_W'(run_c);
                    run_free       <= free_now[FREE_W-1:0];
                  end
                  state <= S_PUMP;
                end
              end
            endcase
          end
        end
        S_HDR: begin
          hdr_idx <= hdr_idx + 3'd1;
          if (hdr_idx == 3'(HDR_BYTES)) begin
            slot_len[tail] <= pay_pos;
            slot_off[tail] <= '0;
            tail           <= tail_inc;
            held           <= held + HELD_W'(1);
            stat_code      <= STS_OK;
            stat_free      <= free_commit[FREE_W-1:0];
            build_len      <= '0;
            build_ovf      <= 1'b0;
            build_blk      <= 1'b0;
            state          <= S_STAT;
          end
        end
        S_STAT: begin
          if (out_open) begin
            state <= S_IDLE;
          end
        end
        default: begin
          if (issue) begin
            rd_pos    <= rd_pos + POS_W'(1);
            rd_left   <= rd_left - RUN_W'(1);
            pend      <= 1'b1;
            pend_last <= (rd_left == RUN_W'(1));
          end else if (move) begin
            pend <= 1'b0;
          end
          if ((rd_left == '0) && !pend) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_STAT) && out_open) begin
      m_tvalid   <= 1'b1;
      out_kind   <= KIND_STATUS;
      out_byte   <= '0;
      out_last   <= 1'b0;
      out_status <= stat_code;
      out_free   <= stat_free;
    end else if (move) begin
      m_tvalid   <= 1'b1;
      out_kind   <= KIND_BYTE;
      out_byte   <= rd_data;
      out_last   <= pend_last;
      out_status <= STS_OK;
      out_free   <= run_free;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {2'b00, out_free, out_status, out_byte};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

endmodule

@@ hdl/lpftxq_checker.sv @@
// port-level checks of the frame transmit queue, bound to the top level
`include "assert_macros.svh"

module lpftxq_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [1:0]                        s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [lpftxq_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [0:0]                        m_tuser,
  input logic                              m_tlast
);

  import lpftxq_pkg::*;

  // a stalled result beat holds still
  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")

  // status beats carry no byte and no run end
  `ASSERT_IMPL(a_status_clean, clk, rst, m_tvalid && (m_tuser[0] == KIND_STATUS), !m_tlast && (m_tdata[7:0] == 8'h00), "status beat with byte or tlast")

  // byte beats carry a zero status
  `ASSERT_IMPL(a_byte_status, clk, rst, m_tvalid && (m_tuser[0] == KIND_BYTE), m_tdata[9:8] == STS_OK, "byte beat with non-zero status")

  // an end beat always keeps the input busy for its status
  `ASSERT_NEXT(a_end_busy, clk, rst, s_tvalid && s_tready && (s_tuser == OP_END), !s_tready, "input ready right after an end beat")

  // no status code outside the defined set
  `ASSERT_IMPL(a_status_code, clk, rst, m_tvalid && (m_tuser[0] == KIND_STATUS), (m_tdata[9:8] == STS_OK) || (m_tdata[9:8] == STS_TOO_LONG) || (m_tdata[9:8] == STS_QUEUE_FULL), "undefined status code")

endmodule

bind length_prefixed_frame_tx_queue_top lpftxq_checker u_lpftxq_checker (.*);
